@@ rtl/diff_drive_odometry_core_assert.svh @@
// assertion macros for the odometry core
// used by diff_drive_odometry_core.sv, expects clk and rst_n in scope
`ifndef DIFF_DRIVE_ODOMETRY_CORE_ASSERT_SVH
`define DIFF_DRIVE_ODOMETRY_CORE_ASSERT_SVH

// same-cycle implication
`define DDO_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define DDO_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/ddo_pkg.sv @@
// constants and helpers for the odometry core
// no dependencies
package ddo_pkg;

  localparam int MulW  = 34;
  localparam int ProdW = 68;

  // radians (Q.F) to binary angle scale and gain-corrected cordic start
  localparam logic signed [MulW-1:0] RadToBam  = 34'sd683565276;
  localparam logic signed [MulW-1:0] CordicOne = 34'sd652032874;

  function automatic logic signed [MulW-1:0] atan_bam(input logic [3:0] i);
    logic signed [MulW-1:0] v;
    unique case (i)
      4'd0:  v = 34'sd536870912;
      4'd1:  v = 34'sd316933406;
      4'd2:  v = 34'sd167458907;
      4'd3:  v = 34'sd85004756;
      4'd4:  v = 34'sd42667331;
      4'd5:  v = 34'sd21354465;
      4'd6:  v = 34'sd10679838;
      4'd7:  v = 34'sd5340245;
      4'd8:  v = 34'sd2670163;
      4'd9:  v = 34'sd1335087;
      4'd10: v = 34'sd667544;
      4'd11: v = 34'sd333772;
      4'd12: v = 34'sd166886;
      4'd13: v = 34'sd83443;
      4'd14: v = 34'sd41722;
      default: v = 34'sd20861;
    endcase
    return v;
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [ProdW-1:0] v);
    logic signed [31:0] r;
    if (v > 68'sd2147483647) r = 32'sh7fffffff;
    else if (v < -68'sd2147483648) r = 32'sh80000000;
    else r = v[31:0];
    return r;
  endfunction

  function automatic logic signed [15:0] sat16(input logic signed [MulW-1:0] v);
    logic signed [15:0] r;
    if (v > 34'sd32767) r = 16'sh7fff;
    else if (v < -34'sd32768) r = 16'sh8000;
    else r = v[15:0];
    return r;
  endfunction

endpackage

@@ rtl/diff_drive_odometry_core.sv @@
// differential drive wheel odometry core
// depends on ddo_pkg and diff_drive_odometry_core_assert.svh
//
// usage:
//   input channel in_valid/in_ready carries one request of two raw encoder
//   counts; in_ready is high only while the core is idle
//   result channel out_valid/out_ready carries pose, velocities and the
//   yaw quaternion terms from an output register
//   cfg_we/cfg_index/cfg_wdata writes metres_per_tick (0), inverse_track (1)
//   and sample_rate (2); other indexes are ignored
// sequencing:
//   a new request is taken only from idle, after any previous result has
//   entered the output register; a request takes two passes of the 16-step
//   cordic and nine uses of the one shared 34x34 multiplier
// reset:
//   synchronous active-low; previous counts and pose clear to zero and the
//   registers take their default values
// stall:
//   a finished result waits in the output register; if a new result is done
//   while the old one is still held, the core waits before loading it
`include "diff_drive_odometry_core_assert.svh"

module diff_drive_odometry_core #(
  parameter int COUNT_BITS = 16,
  parameter int FRAC_BITS  = 16
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [COUNT_BITS-1:0] in_left_count,
  input  logic [COUNT_BITS-1:0] in_right_count,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic signed [31:0]    out_pos_x,
  output logic signed [31:0]    out_pos_y,
  output logic signed [31:0]    out_heading,
  output logic signed [31:0]    out_linear_velocity,
  output logic signed [31:0]    out_yaw_rate,
  output logic signed [15:0]    out_quat_z,
  output logic signed [15:0]    out_quat_w,
  input  logic                  cfg_we,
  input  logic [1:0]            cfg_index,
  input  logic [31:0]           cfg_wdata
);

  localparam int MW = ddo_pkg::MulW;
  localparam int PW = ddo_pkg::ProdW;

  // register indexes
  localparam logic [1:0] CFG_MPT = 2'd0;
  localparam logic [1:0] CFG_INV = 2'd1;
  localparam logic [1:0] CFG_SR  = 2'd2;

  // sequencer states
  localparam logic [4:0] S_IDLE  = 5'd0;
  localparam logic [4:0] S_ML    = 5'd1;   // left ticks * metres_per_tick
  localparam logic [4:0] S_MR    = 5'd2;   // right ticks * metres_per_tick
  localparam logic [4:0] S_SUM   = 5'd3;
  localparam logic [4:0] S_DIFF  = 5'd4;
  localparam logic [4:0] S_MT    = 5'd5;   // diff * inverse_track
  localparam logic [4:0] S_TURN  = 5'd6;
  localparam logic [4:0] S_MID   = 5'd7;
  localparam logic [4:0] S_MB1   = 5'd8;   // midpoint heading to binary angle
  localparam logic [4:0] S_CINIT = 5'd9;
  localparam logic [4:0] S_CORD  = 5'd10;
  localparam logic [4:0] S_MX    = 5'd11;
  localparam logic [4:0] S_MY    = 5'd12;
  localparam logic [4:0] S_MLIN  = 5'd13;
  localparam logic [4:0] S_MANG  = 5'd14;
  localparam logic [4:0] S_MB2   = 5'd15;  // half heading to binary angle
  localparam logic [4:0] S_QUAT  = 5'd16;
  localparam logic [4:0] S_DONE  = 5'd17;

  logic [4:0] state_r, state_nxt;

  // configuration
  logic [31:0] mpt_r, inv_r;
  logic [9:0]  sr_r;

  // pose state
  logic [COUNT_BITS-1:0] prev_l_r, prev_r_r;
  logic signed [31:0]    acc_x_r, acc_y_r, acc_h_r;

  // per-request working registers
  logic signed [COUNT_BITS-1:0] tl_r, tr_r;
  logic signed [31:0] dl_r, dr_r, centre_r, diff_r, turn_r, lin_r, ang_r;
  logic signed [MW-1:0] mid_r;
  logic signed [PW-1:0] prod_r;
  logic signed [15:0]   qz_r, qw_r;

  // cordic unit
  logic signed [MW-1:0] cx_r, cy_r, cz_r;
  logic [3:0] ci_r;
  logic       flip_r, pass_r;

  // shared multiplier operands
  logic signed [MW-1:0] mul_a, mul_b;

  logic in_acc;
  assign in_acc   = in_valid && in_ready;
  assign in_ready = (state_r == S_IDLE);

  // wheel travel: round to Q.F and saturate
  function automatic logic signed [31:0] travel(input logic signed [PW-1:0] p);
    logic signed [PW-1:0] r;
    r = (p + (PW'(1) <<< (31 - FRAC_BITS))) >>> (32 - FRAC_BITS);
    return ddo_pkg::sat32(r);
  endfunction

  // combinational helpers
  logic signed [MW-1:0] tl_x, tr_x, sum_w, dsub_w, t33, half_t, mid_w;
  logic signed [PW-1:0] rnd_w;
  logic [31:0]          bam_w;
  logic                 flip_w;
  logic signed [MW-1:0] sx, sy, cx_n, cy_n, cz_n, at_w;
  logic signed [MW-1:0] qz_rnd, qw_rnd;

  assign tl_x = MW'(tl_r);
  assign tr_x = MW'(tr_r);
  assign sum_w  = MW'(dl_r) + MW'(dr_r) + MW'(1);
  assign dsub_w = MW'(dr_r) - MW'(dl_r);
  assign t33    = MW'(turn_r) + MW'(1);
  assign half_t = t33 >>> 1;
  assign mid_w  = MW'(acc_h_r) + half_t;
  assign rnd_w  = (prod_r + (PW'(1) <<< 29)) >>> 30;
  assign bam_w  = pass_r ? prod_r[FRAC_BITS+1 +: 32] : prod_r[FRAC_BITS +: 32];
  assign flip_w = bam_w[31] ^ bam_w[30];

  // one cordic rotation step
  assign sx   = cx_r >>> ci_r;
  assign sy   = cy_r >>> ci_r;
  assign at_w = ddo_pkg::atan_bam(ci_r);
  always_comb begin
    if (!cz_r[MW-1]) begin
      cx_n = cx_r - sy;
      cy_n = cy_r + sx;
      cz_n = cz_r - at_w;
    end else begin
      cx_n = cx_r + sy;
      cy_n = cy_r - sx;
      cz_n = cz_r + at_w;
    end
  end

  assign qz_rnd = (cy_r + MW'(16384)) >>> 15;
  assign qw_rnd = (cx_r + MW'(16384)) >>> 15;

  // multiplier operand select
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state_r)
      S_ML:   begin mul_a = tl_x;           mul_b = MW'(mpt_r); end
      S_MR:   begin mul_a = tr_x;           mul_b = MW'(mpt_r); end
      S_MT:   begin mul_a = MW'(diff_r);    mul_b = MW'(inv_r); end
      S_MB1:  begin mul_a = mid_r;          mul_b = ddo_pkg::RadToBam; end
      S_MX:   begin mul_a = MW'(centre_r);  mul_b = cx_r; end
      S_MY:   begin mul_a = MW'(centre_r);  mul_b = cy_r; end
      S_MLIN: begin mul_a = MW'(centre_r);  mul_b = MW'(sr_r); end
      S_MANG: begin mul_a = MW'(turn_r);    mul_b = MW'(sr_r); end
      S_MB2:  begin mul_a = MW'(acc_h_r);   mul_b = ddo_pkg::RadToBam; end
      default: begin mul_a = '0;            mul_b = '0; end
    endcase
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE:  if (in_acc) state_nxt = S_ML;
      S_ML:    state_nxt = S_MR;
      S_MR:    state_nxt = S_SUM;
      S_SUM:   state_nxt = S_DIFF;
      S_DIFF:  state_nxt = S_MT;
      S_MT:    state_nxt = S_TURN;
      S_TURN:  state_nxt = S_MID;
      S_MID:   state_nxt = S_MB1;
      S_MB1:   state_nxt = S_CINIT;
      S_CINIT: state_nxt = S_CORD;
      S_CORD:  if (ci_r == 4'd15) state_nxt = pass_r ? S_QUAT : S_MX;
      S_MX:    state_nxt = S_MY;
      S_MY:    state_nxt = S_MLIN;
      S_MLIN:  state_nxt = S_MANG;
      S_MANG:  state_nxt = S_MB2;
      S_MB2:   state_nxt = S_CINIT;
      S_QUAT:  state_nxt = S_DONE;
      S_DONE:  if (!out_valid || out_ready) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  // control and state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      mpt_r     <= 32'd3583399;
      inv_r     <= 32'd198594;
      sr_r      <= 10'd10;
      prev_l_r  <= '0;
      prev_r_r  <= '0;
      acc_x_r   <= '0;
      acc_y_r   <= '0;
      acc_h_r   <= '0;
      out_valid <= 1'b0;
      pass_r    <= 1'b0;
      ci_r      <= '0;
    end else begin
      state_r <= state_nxt;
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_MPT: mpt_r <= cfg_wdata;
          CFG_INV: inv_r <= cfg_wdata;
          CFG_SR:  sr_r  <= cfg_wdata[9:0];
          default: ;
        endcase
      end
      if (in_acc) begin
        prev_l_r <= in_left_count;
        prev_r_r <= in_right_count;
        pass_r   <= 1'b0;
      end
      if (state_r == S_MB2) pass_r <= 1'b1;
      if (state_r == S_CINIT) ci_r <= '0;
      else if (state_r == S_CORD) ci_r <= ci_r + 4'd1;
      // pose update
      if (state_r == S_MY)   acc_x_r <= acc_x_r + rnd_w[31:0];
      if (state_r == S_MLIN) begin
        acc_y_r <= acc_y_r + rnd_w[31:0];
        acc_h_r <= acc_h_r + turn_r;
      end
      if (state_r == S_DONE && (!out_valid || out_ready)) out_valid <= 1'b1;
      else if (out_valid && out_ready) out_valid <= 1'b0;
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    prod_r <= mul_a * mul_b;
    if (in_acc) begin
      tl_r <= in_left_count - prev_l_r;
      tr_r <= in_right_count - prev_r_r;
    end
    unique case (state_r)
      S_MR:   dl_r <= travel(prod_r);
      S_SUM:  dr_r <= travel(prod_r);
      S_DIFF: begin
        centre_r <= 32'(sum_w >>> 1);
        diff_r   <= ddo_pkg::sat32(PW'(dsub_w));
      end
      S_TURN: turn_r <= ddo_pkg::sat32((prod_r + (PW'(1) <<< 15)) >>> 16);
      S_MID:  mid_r  <= mid_w;
      S_CINIT: begin
        // fold into [-pi/2, pi/2)
        flip_r <= flip_w;
        cz_r   <= MW'($signed(flip_w ? (bam_w ^ 32'h80000000) : bam_w));
        cx_r   <= ddo_pkg::CordicOne;
        cy_r   <= '0;
      end
      S_CORD: begin
        cz_r <= cz_n;
        if (ci_r == 4'd15 && flip_r) begin
          cx_r <= -cx_n;
          cy_r <= -cy_n;
        end else begin
          cx_r <= cx_n;
          cy_r <= cy_n;
        end
      end
      S_MANG: lin_r <= ddo_pkg::sat32(prod_r);
      S_MB2:  ang_r <= ddo_pkg::sat32(prod_r);
      S_QUAT: begin
        qz_r <= ddo_pkg::sat16(qz_rnd);
        qw_r <= ddo_pkg::sat16(qw_rnd);
      end
      default: ;
    endcase
    if (state_r == S_DONE && (!out_valid || out_ready)) begin
      out_pos_x            <= acc_x_r;
      out_pos_y            <= acc_y_r;
      out_heading          <= acc_h_r;
      out_linear_velocity  <= lin_r;
      out_yaw_rate         <= ang_r;
      out_quat_z           <= qz_r;
      out_quat_w           <= qw_r;
    end
  end

  // busy right after a request is taken
  `DDO_ASSERT_NEXT(a_busy_after_req, in_acc, !in_ready, "ready after request")
  // a held result is never overwritten
  `DDO_ASSERT_NEXT(a_hold_done, state_r == S_DONE && out_valid && !out_ready,
                   state_r == S_DONE, "result overwritten while stalled")
  // cordic runs exactly sixteen steps
  `DDO_ASSERT_NEXT(a_cordic_len, state_r == S_CORD && ci_r == 4'd15,
                   state_r != S_CORD, "cordic overran")
  // cordic steps only start from zero
  `DDO_ASSERT_NEXT(a_cordic_start, state_r == S_CINIT, ci_r == 4'd0,
                   "cordic counter not cleared")

endmodule

@@ bench/ddo_tb_pkg.sv @@
`timescale 1ns / 100ps
// register indexes shared by the odometry bench top and its checker
// no dependencies
package ddo_tb_pkg;

  typedef enum logic [1:0] {
    REG_METRES_PER_TICK = 2'd0,
    REG_INVERSE_TRACK   = 2'd1,
    REG_SAMPLE_RATE     = 2'd2,
    REG_UNUSED          = 2'd3
  } cfg_reg_e;

endpackage

@@ bench/diff_drive_odometry_checker.sv @@
`timescale 1ns / 100ps
// odometry checker: mirrors configuration, predicts each pose result and compares
// depends on ddo_tb_pkg
module diff_drive_odometry_checker (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic               in_ready,
  input  logic [15:0]        in_left_count,
  input  logic [15:0]        in_right_count,
  input  logic               out_valid,
  input  logic               out_ready,
  input  logic signed [31:0] out_pos_x,
  input  logic signed [31:0] out_pos_y,
  input  logic signed [31:0] out_heading,
  input  logic signed [31:0] out_linear_velocity,
  input  logic signed [31:0] out_yaw_rate,
  input  logic signed [15:0] out_quat_z,
  input  logic signed [15:0] out_quat_w,
  input  logic               cfg_we,
  input  logic [1:0]         cfg_index,
  input  logic [31:0]        cfg_wdata,
  output int                 fail_count,
  output int                 pending
);

  typedef struct {
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] heading;
    logic signed [31:0] lin_vel;
    logic signed [31:0] ang_vel;
    logic signed [15:0] quat_z;
    logic signed [15:0] quat_w;
  } pose_t;

  localparam longint ATAN_BAM [16] = '{
    536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
    10679838, 5340245, 2670163, 1335087, 667544, 333772,
    166886, 83443, 41722, 20861
  };

  bit [31:0] metres_per_tick, inverse_track;
  bit [9:0]  sample_rate;
  bit [15:0] last_left, last_right;
  bit [31:0] pose_x, pose_y, pose_heading;
  pose_t     expected_poses[$];

  assign pending = expected_poses.size();

  function automatic longint round_shr(longint v, int s);
    return (v + (longint'(1) << (s - 1))) >>> s;
  endfunction

  function automatic longint clip(longint v, longint lo, longint hi);
    return v < lo ? lo : (v > hi ? hi : v);
  endfunction

  function automatic longint clip32(longint v);
    return clip(v, -64'sd2147483648, 64'sd2147483647);
  endfunction

  function automatic longint tick_delta(bit [15:0] cur, bit [15:0] prev);
    bit [15:0] d;
    d = cur - prev;
    return longint'($signed(d));
  endfunction

  function automatic bit [31:0] rad_to_bam(longint rad, int shift);
    bit [63:0] p;
    p = rad * 64'd683565276;
    return 32'(p >> shift);
  endfunction

  // 16-step rotation cordic with half-turn fold, q2.30 outputs
  function automatic void cordic_sin_cos(bit [31:0] bam, output longint c, output longint s);
    bit [31:0] fold_chk, zr;
    bit        flip;
    longint    x, y, z, dx, dy;
    fold_chk = bam + 32'h40000000;
    flip = fold_chk[31];
    zr = flip ? bam - 32'h80000000 : bam;
    z = longint'($signed(zr));
    x = 652032874;
    y = 0;
    for (int i = 0; i < 16; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (z >= 0) begin
        x -= dx; y += dy; z -= ATAN_BAM[i];
      end else begin
        x += dx; y -= dy; z += ATAN_BAM[i];
      end
    end
    c = flip ? -x : x;
    s = flip ? -y : y;
  endfunction

  function automatic pose_t advance_pose(bit [15:0] l, bit [15:0] r);
    pose_t  p;
    longint dl, dr, centre, turn, mid, c, s;
    dl = clip32(round_shr(tick_delta(l, last_left) * longint'(metres_per_tick), 16));
    dr = clip32(round_shr(tick_delta(r, last_right) * longint'(metres_per_tick), 16));
    last_left = l;
    last_right = r;
    centre = round_shr(dl + dr, 1);
    turn = clip32(round_shr(clip32(dr - dl) * longint'(inverse_track), 16));
    mid = longint'($signed(pose_heading)) + round_shr(turn, 1);
    cordic_sin_cos(rad_to_bam(mid, 16), c, s);
    pose_x += 32'(round_shr(centre * c, 30));
    pose_y += 32'(round_shr(centre * s, 30));
    pose_heading += 32'(turn);
    p.pos_x = pose_x;
    p.pos_y = pose_y;
    p.heading = pose_heading;
    p.lin_vel = 32'(clip32(centre * longint'(sample_rate)));
    p.ang_vel = 32'(clip32(turn * longint'(sample_rate)));
    cordic_sin_cos(rad_to_bam(longint'($signed(pose_heading)), 17), c, s);
    p.quat_z = 16'(clip(round_shr(s, 15), -32768, 32767));
    p.quat_w = 16'(clip(round_shr(c, 15), -32768, 32767));
    return p;
  endfunction

  task automatic report_mismatch(string field, longint got, longint want);
    fail_count++;
    $display("[%0t] %s: got %0d, want %0d", $time, field, got, want);
  endtask

  task automatic compare_field(string field, longint got, longint want);
    if (got != want) report_mismatch(field, got, want);
  endtask

  initial fail_count = 0;

  always @(posedge clk) begin
    pose_t w;
    if (!rst_n) begin
      metres_per_tick = 32'd3583399;
      inverse_track = 32'd198594;
      sample_rate = 10'd10;
      last_left = '0;
      last_right = '0;
      pose_x = '0;
      pose_y = '0;
      pose_heading = '0;
      expected_poses.delete();
    end else begin
      if (cfg_we) begin
        case (ddo_tb_pkg::cfg_reg_e'(cfg_index))
          ddo_tb_pkg::REG_METRES_PER_TICK: metres_per_tick = cfg_wdata;
          ddo_tb_pkg::REG_INVERSE_TRACK:   inverse_track = cfg_wdata;
          ddo_tb_pkg::REG_SAMPLE_RATE:     sample_rate = cfg_wdata[9:0];
          default: ;
        endcase
      end
      if (in_valid && in_ready) begin
        expected_poses.insert(expected_poses.size(),
                              advance_pose(in_left_count, in_right_count));
      end
      if (out_valid && out_ready) begin
        if (expected_poses.size() == 0) begin
          report_mismatch("unexpected result", 1, 0);
        end else begin
          w = expected_poses.pop_front();
          compare_field("pos_x", out_pos_x, w.pos_x);
          compare_field("pos_y", out_pos_y, w.pos_y);
          compare_field("heading", out_heading, w.heading);
          compare_field("linear_velocity", out_linear_velocity, w.lin_vel);
          compare_field("yaw_rate", out_yaw_rate, w.ang_vel);
          compare_field("quat_z", out_quat_z, w.quat_z);
          compare_field("quat_w", out_quat_w, w.quat_w);
        end
      end
    end
  end

endmodule

@@ bench/diff_drive_odometry_core_tb.sv @@
`timescale 1ns / 100ps
// bench top for the odometry core: clock, reset, encoder requests, config phases
// depends on ddo_tb_pkg, diff_drive_odometry_checker and the core rtl
module diff_drive_odometry_core_tb;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic [15:0]        in_left_count = '0;
  logic [15:0]        in_right_count = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic signed [31:0] out_pos_x, out_pos_y, out_heading;
  logic signed [31:0] out_linear_velocity, out_yaw_rate;
  logic signed [15:0] out_quat_z, out_quat_w;
  logic               cfg_we = 1'b0;
  logic [1:0]         cfg_index = '0;
  logic [31:0]        cfg_wdata = '0;

  int fail_count, pending;
  int requests_sent = 0;
  int config_phases = 0;
  bit quiet = 1'b0;        // no idling on either side when set
  int stall_left = 0;
  bit [15:0] cur_left = '0, cur_right = '0;

  always #1 clk = ~clk;

  diff_drive_odometry_core u_top (.*);

  diff_drive_odometry_checker u_checker (.*);

  // result side back-pressure: out_ready is randomly held low
  always @(posedge clk) begin
    if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_ready <= 1'b0;
    end else if (!quiet && $urandom_range(0, 5) == 0) begin
      stall_left <= $urandom_range(0, 4);
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  // one encoder request; valid is only lowered when a gap is inserted
  task automatic send_counts(bit [15:0] l, bit [15:0] r);
    if (!quiet && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_left_count <= l;
    in_right_count <= r;
    cur_left = l;
    cur_right = r;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    requests_sent++;
  endtask

  // drain, let the core settle, then write all registers plus an unused index
  task automatic load_config(bit [31:0] mpt, bit [31:0] inv, bit [31:0] rate);
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (60) @(posedge clk);
    cfg_we <= 1'b1; cfg_index <= ddo_tb_pkg::REG_METRES_PER_TICK; cfg_wdata <= mpt;
    @(posedge clk);
    cfg_index <= ddo_tb_pkg::REG_INVERSE_TRACK; cfg_wdata <= inv;
    @(posedge clk);
    cfg_index <= ddo_tb_pkg::REG_SAMPLE_RATE; cfg_wdata <= rate;
    @(posedge clk);
    // unused index must be ignored
    cfg_index <= ddo_tb_pkg::REG_UNUSED; cfg_wdata <= $urandom;
    @(posedge clk);
    cfg_we <= 1'b0;
    config_phases++;
  endtask

  // random motion: mostly small steps from the last counts, some full-range jumps and half-range steps
  task automatic random_motion(int n);
    bit [15:0] l, r;
    for (int i = 0; i < n; i++) begin
      case ($urandom_range(0, 9))
        0, 1: begin
          l = 16'($urandom);
          r = 16'($urandom);
        end
        2: begin
          l = cur_left + 16'h8000;
          r = cur_right + 16'(int'($urandom_range(0, 20)) - 10);
        end
        default: begin
          l = cur_left + 16'(int'($urandom_range(0, 600)) - 300);
          r = cur_right + 16'(int'($urandom_range(0, 600)) - 300);
        end
      endcase
      send_counts(l, r);
    end
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: default registers, first step against zero counts
    send_counts(16'd0, 16'd0);
    send_counts(16'd100, 16'd100);         // straight ahead
    send_counts(16'd50, 16'd150);          // turn left
    send_counts(16'd250, 16'd150);         // turn right
    send_counts(16'd100, 16'd0);           // backwards
    send_counts(16'hffff, 16'hffff);       // wrap behind zero
    send_counts(16'h0005, 16'h0003);       // wrap forward
    send_counts(16'h8005, 16'h0003);       // half-range change reads as backwards
    send_counts(16'h8005, 16'h8003);
    send_counts(16'h0000, 16'hffff);
    send_counts(16'h5555, 16'haaaa);
    send_counts(16'haaaa, 16'h5555);
    for (int i = 0; i < 8; i++) send_counts(cur_left - 16'd700, cur_right + 16'd700);

    // extreme travel per tick and track, saturating velocities
    load_config(32'hffffffff, 32'hffffffff, 32'd1023);
    send_counts(cur_left + 16'h7fff, cur_right - 16'h7fff);
    send_counts(cur_left + 16'h8000, cur_right + 16'h8000);
    random_motion(60);

    load_config(32'd1, 32'd1, 32'd1);
    random_motion(60);

    load_config($urandom, $urandom, $urandom_range(1, 1023));
    random_motion(80);

    load_config(32'd3583399, 32'd198594, 32'd10);
    random_motion(80);

    load_config($urandom_range(1000000, 40000000), $urandom_range(50000, 400000),
                $urandom_range(1, 1023));
    random_motion(80);

    // last stretch runs back to back with no idling
    load_config($urandom, $urandom_range(1, 600000), 32'd1023);
    quiet = 1'b1;
    random_motion(80);
    in_valid <= 1'b0;

    while (pending != 0) @(posedge clk);
    repeat (80) @(posedge clk);

    $display("sent %0d encoder requests over %0d register settings", requests_sent,
             config_phases + 1);
    $display("includes wraps, half-range steps and saturating travel");
    if (fail_count == 0 && pending == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  // watchdog
  initial begin
    #2000000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
